// ===== rtl/core/ihex_pkg.sv =====
// Shared types and constants for the Intel HEX record encoder.
// Has no dependencies. Used by the encoder, its output stage and its checker.
package ihex_pkg;

    localparam logic [1:0] KIND_COLON = 2'd0;
    localparam logic [1:0] KIND_HEX   = 2'd1;
    localparam logic [1:0] KIND_EOL   = 2'd2;

    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [7:0] REC_TYPE_EOF  = 8'h01;

    localparam logic [15:0] LOAD_ADDR_RESET = 16'h8000;

    // colon, count, address high, address low, type
    localparam int HDR_ITEMS = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  byte_value;
        logic [15:0] hex_chars;
        logic        last_of_run;
        logic        stream_end;
    } out_item_t;

    // One item from the record sequencer to the output stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
        logic       stream_end;
    } emit_req_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h37 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/ihex_out.sv =====
// Output register of the Intel HEX encoder: formats one item into hex ASCII.
// Depends on ihex_pkg.
module ihex_out
    import ihex_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  emit_req_t push_req,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      valid_reg;
    out_item_t item_reg;
    out_item_t item_next;

    assign push_ready = !valid_reg || m_ready;

    always_comb begin
        item_next.item_kind   = push_req.kind;
        item_next.last_of_run = push_req.last;
        item_next.stream_end  = push_req.stream_end;
        if (push_req.kind == KIND_HEX) begin
            item_next.byte_value = push_req.value;
            item_next.hex_chars  = {hex_ascii(push_req.value[7:4]),
                                    hex_ascii(push_req.value[3:0])};
        end else begin
            item_next.byte_value = 8'd0;
            item_next.hex_chars  = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ready && push_valid) begin
            item_reg <= item_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = item_reg;

endmodule

// ===== rtl/core/intel_hex_record_encoder.sv =====
// Intel HEX record encoder top level: byte buffer memory and record sequencer.
// Depends on ihex_pkg and ihex_out.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  s_       | s_valid s_ready s_data         | image bytes, final flag
//  m_       | m_valid m_ready m_data         | colon, hex byte, line end items
//  cfg_     | cfg_wr_en cfg_wr_data          | load address, no wait
//
// A byte that only fills the buffer is stored on accept. A full buffer that is
// not all zero is flushed as RECORD_BYTES+7 items, one per cycle, from the
// buffer memory (one read port, registered read); the ST_STORE state then
// stores the new byte. A final byte adds count+7 items for its record and 6 for
// the end record. No clearing pass after reset: buffer entries are read only
// once written. m_ready low freezes the sequencer; s_ready is low while it runs.
module intel_hex_record_encoder
    import ihex_pkg::*;
#(
    parameter int RECORD_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int FILL_W = $clog2(RECORD_BYTES + 1);
    localparam int STEP_W = $clog2(RECORD_BYTES + HDR_ITEMS + 3);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STORE  = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_FINAL  = 3'd3;
    localparam logic [2:0] ST_ENDREC = 3'd4;

    logic [7:0] buf_mem [RECORD_BYTES];
    logic [7:0] rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              all_zero_reg, all_zero_next;
    logic [15:0]       raddr_reg, raddr_next;
    logic [15:0]       load_addr_reg, load_addr_next;
    logic [7:0]        byte_reg;
    logic              fin_reg;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        sum_reg, sum_next;
    logic [FILL_W-1:0] rec_count_reg;
    logic [15:0]       rec_addr_reg;
    logic [7:0]        rec_type_reg;
    logic              rec_le_reg, rec_last_reg, rec_end_reg;

    logic              launch_en;
    logic [FILL_W-1:0] launch_count;
    logic [15:0]       launch_addr;
    logic [7:0]        launch_type;
    logic              launch_le, launch_last, launch_end;

    logic              st_en, st_fin;
    logic [7:0]        st_byte;
    logic              s_fire, full;
    logic              emitting, push_ready, fire, is_last;
    logic [STEP_W-1:0] cks_step, last_step;
    emit_req_t         req;

    assign full     = (fill_reg == FILL_W'(RECORD_BYTES));
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign emitting = (state_reg == ST_FLUSH) || (state_reg == ST_FINAL)
                   || (state_reg == ST_ENDREC);
    assign fire     = emitting && push_ready;

    // Item generation for the record in progress
    always_comb begin
        cks_step  = STEP_W'(HDR_ITEMS) + STEP_W'(rec_count_reg);
        last_step = rec_le_reg ? cks_step + STEP_W'(1) : cks_step;
        is_last   = (step_reg == last_step);
        req.kind  = KIND_HEX;
        req.value = 8'd0;
        if (step_reg == STEP_W'(0)) begin
            req.kind = KIND_COLON;
        end else if (step_reg == STEP_W'(1)) begin
            req.value = 8'(rec_count_reg);
        end else if (step_reg == STEP_W'(2)) begin
            req.value = rec_addr_reg[15:8];
        end else if (step_reg == STEP_W'(3)) begin
            req.value = rec_addr_reg[7:0];
        end else if (step_reg == STEP_W'(4)) begin
            req.value = rec_type_reg;
        end else if (step_reg < cks_step) begin
            req.value = rd_data_reg;
        end else if (step_reg == cks_step) begin
            req.value = 8'd0 - sum_reg;
        end else begin
            req.kind = KIND_EOL;
        end
        req.last       = is_last && rec_last_reg;
        req.stream_end = is_last && rec_end_reg;
    end

    // Store path: direct on accept, or latched byte after a full buffer is flushed or dropped as all zero
    always_comb begin
        st_en   = (s_fire && !full) || (state_reg == ST_STORE);
        st_byte = (state_reg == ST_STORE) ? byte_reg : s_data.data_byte;
        st_fin  = (state_reg == ST_STORE) ? fin_reg : s_data.final_byte;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        all_zero_next  = all_zero_reg;
        raddr_next     = raddr_reg;
        load_addr_next = load_addr_reg;
        launch_en      = 1'b0;
        launch_count   = fill_reg + FILL_W'(1);
        launch_addr    = raddr_reg;
        launch_type    = REC_TYPE_DATA;
        launch_le      = 1'b1;
        launch_last    = 1'b0;
        launch_end     = 1'b0;

        if (s_fire && full) begin
            raddr_next    = raddr_reg + 16'(RECORD_BYTES);
            fill_next     = '0;
            all_zero_next = 1'b1;
            if (!all_zero_reg) begin
                launch_en    = 1'b1;
                launch_count = FILL_W'(RECORD_BYTES);
                launch_last  = !s_data.final_byte;
                state_next   = ST_FLUSH;
            end else begin
                state_next   = ST_STORE;
            end
        end

        if (st_en) begin
            fill_next     = fill_reg + FILL_W'(1);
            all_zero_next = all_zero_reg && (st_byte == 8'd0);
            state_next    = ST_IDLE;
            if (st_fin) begin
                launch_en     = 1'b1;
                fill_next     = '0;
                all_zero_next = 1'b1;
                raddr_next    = load_addr_reg;
                state_next    = ST_FINAL;
            end
        end

        if (fire && is_last) begin
            case (state_reg)
                ST_FLUSH: begin
                    state_next = ST_STORE;
                end
                ST_FINAL: begin
                    launch_en    = 1'b1;
                    launch_count = '0;
                    launch_addr  = 16'd0;
                    launch_type  = REC_TYPE_EOF;
                    launch_le    = 1'b0;
                    launch_last  = 1'b1;
                    launch_end   = 1'b1;
                    state_next   = ST_ENDREC;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        if (cfg_wr_en) begin
            load_addr_next = cfg_wr_data;
            raddr_next     = cfg_wr_data;
        end
    end

    // Sequencer counters; the read address runs one item ahead of the data
    always_comb begin
        step_next = step_reg;
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        if (launch_en) begin
            step_next = '0;
            idx_next  = '0;
            sum_next  = 8'd0;
        end else if (fire) begin
            step_next = step_reg + STEP_W'(1);
            if (req.kind == KIND_HEX && step_reg != cks_step) begin
                sum_next = sum_reg + req.value;
            end
            if (step_reg >= STEP_W'(HDR_ITEMS) && step_reg < cks_step) begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            all_zero_reg  <= 1'b1;
            raddr_reg     <= LOAD_ADDR_RESET;
            load_addr_reg <= LOAD_ADDR_RESET;
            step_reg      <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            all_zero_reg  <= all_zero_next;
            raddr_reg     <= raddr_next;
            load_addr_reg <= load_addr_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (s_fire) begin
            byte_reg <= s_data.data_byte;
            fin_reg  <= s_data.final_byte;
        end
        if (launch_en) begin
            rec_count_reg <= launch_count;
            rec_addr_reg  <= launch_addr;
            rec_type_reg  <= launch_type;
            rec_le_reg    <= launch_le;
            rec_last_reg  <= launch_last;
            rec_end_reg   <= launch_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_en) begin
            buf_mem[fill_reg[IDX_W-1:0]] <= st_byte;
        end
        rd_data_reg <= buf_mem[idx_next];
    end

    ihex_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (emitting),
        .push_ready (push_ready),
        .push_req   (req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/core/ihex_enc_checker.sv =====
// Port-level checks for the Intel HEX record encoder, bound to its top level.
// Depends on ihex_pkg and intel_hex_record_encoder.
module ihex_enc_checker
    import ihex_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input out_item_t   m_data
);

    // An end mark only closes a run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stream_end |-> m_data.last_of_run)
        else $error("stream_end without last_of_run");

    // Colon and line end carry no byte
    a_non_hex_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.item_kind != KIND_HEX
        |-> m_data.byte_value == 8'd0 && m_data.hex_chars == 16'd0)
        else $error("non-hex item carries data");

    // Hold intake while a run is still being delivered
    a_no_intake_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_of_run |-> !s_ready)
        else $error("request taken in the middle of a result run");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

endmodule

bind intel_hex_record_encoder ihex_enc_checker u_ihex_enc_checker (.*);
